@@ rtl/round_robin_crossbar_matcher_unit_assert.svh @@
// Assertion macros shared by the matcher RTL.
`ifndef ROUND_ROBIN_CROSSBAR_MATCHER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_CROSSBAR_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RRCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("matcher check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RRCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("matcher check failed");

`endif

@@ rtl/rrcm_pkg.sv @@
// Package with the default sizes and field widths of the round-robin matcher.
package rrcm_pkg;

    // Default switch geometry.
    localparam int NUM_INPUTS_DEF       = 8;
    localparam int NUM_OUTPUTS_DEF      = 8;
    localparam int LINES_PER_OUTPUT_DEF = 1;

    // Fixed field widths.
    localparam int REQ_W   = 64;
    localparam int ITER_W  = 4;
    localparam int INDEX_W = 3;

    // Iteration limit after reset.
    localparam logic [ITER_W-1:0] ITER_RESET = 4'd1;

endpackage

@@ rtl/round_robin_crossbar_matcher_unit.sv @@
// Round-robin matching crossbar scheduler: grant/accept iterations over a request matrix.
//
// One request matrix is taken while the block is idle. Each iteration visits every fabric
// output in turn in the grant phase and every input in turn in the accept phase, since a
// single round-robin arbiter serves one output or one input per cycle. At most the configured
// number of iterations run, fewer when a pass makes no new connection; then one result per
// fabric output is presented, one per cycle while the consumer is ready.
// The block accepts no new request until the last result has been taken.
`include "round_robin_crossbar_matcher_unit_assert.svh"

module round_robin_crossbar_matcher_unit #(
    parameter int NUM_INPUTS       = rrcm_pkg::NUM_INPUTS_DEF,
    parameter int NUM_OUTPUTS      = rrcm_pkg::NUM_OUTPUTS_DEF,
    parameter int LINES_PER_OUTPUT = rrcm_pkg::LINES_PER_OUTPUT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [rrcm_pkg::ITER_W-1:0]  i_cfg_wdata,
    // Request channel.
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [rrcm_pkg::REQ_W-1:0]   i_request_matrix,
    // Result channel.
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [rrcm_pkg::INDEX_W-1:0] o_fabric_output,
    output logic                         o_matched,
    output logic [rrcm_pkg::INDEX_W-1:0] o_matched_input,
    output logic [rrcm_pkg::ITER_W-1:0]  o_iterations_used,
    output logic                         o_last
);

    localparam int FAB       = NUM_OUTPUTS * LINES_PER_OUTPUT;
    localparam int CELLS     = NUM_INPUTS * NUM_OUTPUTS;
    localparam int IN_W      = $clog2(NUM_INPUTS);
    localparam int FAB_W     = $clog2(FAB);
    localparam int SW_W      = $clog2(NUM_OUTPUTS);
    localparam int LINE_W    = (LINES_PER_OUTPUT > 1) ? $clog2(LINES_PER_OUTPUT) : 1;
    localparam int ARB_W     = (NUM_INPUTS > FAB) ? NUM_INPUTS : FAB;
    localparam int ARB_IW    = $clog2(ARB_W);
    localparam int ITER_W    = rrcm_pkg::ITER_W;
    localparam int INDEX_W   = rrcm_pkg::INDEX_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GRANT  = 2'd1;
    localparam logic [1:0] S_ACCEPT = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]                         r_state, n_state;
    logic [ITER_W-1:0]                  r_iter_lim, n_iter_lim;
    logic [ITER_W-1:0]                  r_used, n_used;
    logic                               r_conns, n_conns;
    logic [FAB_W-1:0]                   r_f, n_f;
    logic [SW_W-1:0]                    r_sw, n_sw;
    logic [LINE_W-1:0]                  r_line, n_line;
    logic [IN_W-1:0]                    r_i, n_i;
    logic [NUM_INPUTS-1:0]              r_in_matched, n_in_matched;
    logic [FAB-1:0]                     r_out_matched, n_out_matched;
    logic [FAB-1:0][IN_W-1:0]           r_gnt_ptr, n_gnt_ptr;
    logic [NUM_INPUTS-1:0][FAB_W-1:0]   r_acc_ptr, n_acc_ptr;
    logic [rrcm_pkg::REQ_W-1:0]         r_req, n_req;
    logic [FAB-1:0][IN_W-1:0]           r_out_input, n_out_input;
    logic [NUM_INPUTS-1:0][FAB-1:0]     r_granted, n_granted;

    logic [CELLS-1:0]                   w_req_ext;
    logic [NUM_INPUTS-1:0][NUM_OUTPUTS-1:0] w_req_2d;
    logic [NUM_INPUTS-1:0]              w_col;
    logic [ARB_W-1:0]                   w_arb_vec;
    logic [ARB_IW-1:0]                  w_arb_ptr;
    logic                               w_arb_hit;
    logic [ARB_IW-1:0]                  w_arb_low;
    logic                               w_arb_hi_hit;
    logic [ARB_IW-1:0]                  w_arb_hi;
    logic [ARB_IW-1:0]                  w_arb_pick;
    logic                               w_grant_take;
    logic                               w_acc_take;
    logic                               w_conns_end;
    logic [FAB_W+INDEX_W-1:0]           w_f_ext;
    logic [IN_W+INDEX_W-1:0]            w_in_ext;

    // Request bits beyond the matrix width read as zero.
    assign w_req_ext = CELLS'(r_req);
    assign w_req_2d  = w_req_ext;

    // Request column of the switch output served by the current fabric output.
    always_comb begin
        for (int c = 0; c < NUM_INPUTS; c++) begin
            w_col[c] = w_req_2d[c][r_sw];
        end
    end

    // Operands of the shared round-robin arbiter.
    always_comb begin
        if (r_state == S_ACCEPT) begin
            w_arb_vec = ARB_W'(r_granted[r_i]);
            w_arb_ptr = ARB_IW'(r_acc_ptr[r_i]);
        end else begin
            w_arb_vec = ARB_W'(w_col & ~r_in_matched);
            w_arb_ptr = ARB_IW'(r_gnt_ptr[0]);
        end
    end

    // Shared arbiter: first set bit after the pointer, wrapping to the lowest set bit.
    always_comb begin
        w_arb_hit    = 1'b0;
        w_arb_low    = '0;
        w_arb_hi_hit = 1'b0;
        w_arb_hi     = '0;
        for (int k = ARB_W - 1; k >= 0; k--) begin
            if (w_arb_vec[k]) begin
                w_arb_hit = 1'b1;
                w_arb_low = ARB_IW'(k);
            end
            if (w_arb_vec[k] && (ARB_IW'(k) > w_arb_ptr)) begin
                w_arb_hi_hit = 1'b1;
                w_arb_hi     = ARB_IW'(k);
            end
        end
        w_arb_pick = w_arb_hi_hit ? w_arb_hi : w_arb_low;
    end

    assign w_grant_take = (r_state == S_GRANT) && !r_out_matched[0] && w_arb_hit;
    assign w_acc_take   = (r_state == S_ACCEPT) && !r_in_matched[r_i] && w_arb_hit;
    assign w_conns_end  = r_conns || w_acc_take;

    // Sequencer and datapath next values.
    always_comb begin
        n_state       = r_state;
        n_iter_lim    = i_cfg_we ? i_cfg_wdata : r_iter_lim;
        n_used        = r_used;
        n_conns       = r_conns;
        n_f           = r_f;
        n_sw          = r_sw;
        n_line        = r_line;
        n_i           = r_i;
        n_in_matched  = r_in_matched;
        n_out_matched = r_out_matched;
        n_gnt_ptr     = r_gnt_ptr;
        n_acc_ptr     = r_acc_ptr;
        n_req         = r_req;
        n_out_input   = r_out_input;
        n_granted     = r_granted;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req         = i_request_matrix;
                    n_used        = '0;
                    n_conns       = 1'b0;
                    n_f           = '0;
                    n_sw          = '0;
                    n_line        = '0;
                    n_i           = '0;
                    n_in_matched  = '0;
                    n_out_matched = '0;
                    n_granted     = '0;
                    n_state       = (r_iter_lim == '0) ? S_OUT : S_GRANT;
                end
            end
            S_GRANT: begin
                // The head of each fabric-indexed line is fabric output r_f.
                n_gnt_ptr     = {r_gnt_ptr[0], r_gnt_ptr[FAB-1:1]};
                n_out_matched = {r_out_matched[0], r_out_matched[FAB-1:1]};
                n_out_input   = {r_out_input[0], r_out_input[FAB-1:1]};
                if (w_grant_take) begin
                    n_gnt_ptr[FAB-1]                = w_arb_pick[IN_W-1:0];
                    n_granted[w_arb_pick[IN_W-1:0]][r_f] = 1'b1;
                end
                if (r_line == LINE_W'(LINES_PER_OUTPUT - 1)) begin
                    n_line = '0;
                    n_sw   = r_sw + 1'b1;
                end else begin
                    n_line = r_line + 1'b1;
                end
                if (r_f == FAB_W'(FAB - 1)) begin
                    n_f     = '0;
                    n_sw    = '0;
                    n_line  = '0;
                    n_i     = '0;
                    n_state = S_ACCEPT;
                end else begin
                    n_f = r_f + 1'b1;
                end
            end
            S_ACCEPT: begin
                if (w_acc_take) begin
                    n_acc_ptr[r_i]                       = w_arb_pick[FAB_W-1:0];
                    n_in_matched[r_i]                    = 1'b1;
                    n_out_matched[w_arb_pick[FAB_W-1:0]] = 1'b1;
                    n_out_input[w_arb_pick[FAB_W-1:0]]   = r_i;
                    n_conns                              = 1'b1;
                end
                if (r_i == IN_W'(NUM_INPUTS - 1)) begin
                    n_i = '0;
                    if (!w_conns_end) begin
                        n_state = S_OUT;
                    end else begin
                        n_used = r_used + 1'b1;
                        if (n_used == r_iter_lim) begin
                            n_state = S_OUT;
                        end else begin
                            n_conns   = 1'b0;
                            n_granted = '0;
                            n_state   = S_GRANT;
                        end
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_out_matched = {r_out_matched[0], r_out_matched[FAB-1:1]};
                    n_out_input   = {r_out_input[0], r_out_input[FAB-1:1]};
                    if (r_f == FAB_W'(FAB - 1)) begin
                        n_f     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_f = r_f + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_iter_lim    <= rrcm_pkg::ITER_RESET;
            r_used        <= '0;
            r_conns       <= 1'b0;
            r_f           <= '0;
            r_sw          <= '0;
            r_line        <= '0;
            r_i           <= '0;
            r_in_matched  <= '0;
            r_out_matched <= '0;
            r_gnt_ptr     <= '0;
            r_acc_ptr     <= '0;
        end else begin
            r_state       <= n_state;
            r_iter_lim    <= n_iter_lim;
            r_used        <= n_used;
            r_conns       <= n_conns;
            r_f           <= n_f;
            r_sw          <= n_sw;
            r_line        <= n_line;
            r_i           <= n_i;
            r_in_matched  <= n_in_matched;
            r_out_matched <= n_out_matched;
            r_gnt_ptr     <= n_gnt_ptr;
            r_acc_ptr     <= n_acc_ptr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_out_input <= n_out_input;
        r_granted   <= n_granted;
    end

    // Result fields come from the head of the fabric-indexed lines.
    assign w_f_ext  = FAB_W'(0) == FAB_W'(0) ? {{INDEX_W{1'b0}}, r_f} : '0;
    assign w_in_ext = {{INDEX_W{1'b0}}, r_out_input[0]};

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_OUT);
    assign o_fabric_output   = w_f_ext[INDEX_W-1:0];
    assign o_matched         = r_out_matched[0];
    assign o_matched_input   = r_out_matched[0] ? w_in_ext[INDEX_W-1:0] : '0;
    assign o_iterations_used = r_used;
    assign o_last            = (r_f == FAB_W'(FAB - 1));

    // Every connection pairs exactly one input with one fabric output.
    `RRCM_ASSERT_NOW(a_match_balance, 1'b1, $countones(r_in_matched) == $countones(r_out_matched))
    // An accepted grant never lands on an output that is already connected.
    `RRCM_ASSERT_NOW(a_accept_free_out, w_acc_take, !r_out_matched[w_arb_pick[FAB_W-1:0]])
    // The iteration count never passes the configured limit while a request is in work.
    `RRCM_ASSERT_NOW(a_iter_bound, r_state != S_IDLE, r_used <= r_iter_lim)
    // A taken request starts work at once.
    `RRCM_ASSERT_NEXT(a_req_starts, i_req_valid && o_req_ready, r_state != S_IDLE)
    // Taking the final result returns the block to idle.
    `RRCM_ASSERT_NEXT(a_last_idles, o_res_valid && i_res_ready && o_last, r_state == S_IDLE)

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the round-robin crossbar matcher unit.
module tb;

    localparam int NI = rrcm_pkg::NUM_INPUTS_DEF;
    localparam int NO = rrcm_pkg::NUM_OUTPUTS_DEF;
    localparam int NF = rrcm_pkg::NUM_OUTPUTS_DEF * rrcm_pkg::LINES_PER_OUTPUT_DEF;
    localparam int LPO = rrcm_pkg::LINES_PER_OUTPUT_DEF;
    localparam int REQ_W = rrcm_pkg::REQ_W;
    localparam int ITER_W = rrcm_pkg::ITER_W;
    localparam int INDEX_W = rrcm_pkg::INDEX_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // One expected result: the connection state of one fabric output.
    typedef struct packed {
        logic [INDEX_W-1:0] fabric_output;
        logic               matched;
        logic [INDEX_W-1:0] matched_input;
        logic [ITER_W-1:0]  iterations_used;
        logic               last;
    } t_match_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [ITER_W-1:0]  i_cfg_wdata;
    logic               i_req_valid;
    logic               o_req_ready;
    logic [REQ_W-1:0]   i_request_matrix;
    logic               o_res_valid;
    logic               i_res_ready;
    logic [INDEX_W-1:0] o_fabric_output;
    logic               o_matched;
    logic [INDEX_W-1:0] o_matched_input;
    logic [ITER_W-1:0]  o_iterations_used;
    logic               o_last;

    // Scheduler state mirrored by the predictor.
    logic [INDEX_W-1:0] grant_ptr [NF];
    logic [INDEX_W-1:0] accept_ptr [NI];
    logic [ITER_W-1:0]  iter_limit;

    t_match_result expected_matches[$];
    int unsigned   err_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   res_hold_cycles = 0;
    int unsigned   res_gap_left = 0;
    bit            idle_on = 1'b1;

    round_robin_crossbar_matcher_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_request_matrix  (i_request_matrix),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_fabric_output   (o_fabric_output),
        .o_matched         (o_matched),
        .o_matched_input   (o_matched_input),
        .o_iterations_used (o_iterations_used),
        .o_last            (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result consumer: long holds on demand, short random stalls otherwise while idling is on.
    always @(negedge i_clk) begin
        if (res_hold_cycles != 0) begin
            i_res_ready <= 1'b0;
            res_hold_cycles = res_hold_cycles - 1;
        end else if (res_gap_left != 0) begin
            i_res_ready <= 1'b0;
            res_gap_left = res_gap_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_res_ready <= 1'b0;
            res_gap_left = $urandom_range(0, 2);
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest predicted one.
    always @(posedge i_clk) begin : result_check
        t_match_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected result for fabric output %0d", o_fabric_output);
                err_count++;
            end else begin
                want = expected_matches.pop_front();
                if (o_fabric_output !== want.fabric_output) begin
                    $error("fabric_output: expected %0d, got %0d",
                           want.fabric_output, o_fabric_output);
                    err_count++;
                end
                if (o_matched !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, o_matched);
                    err_count++;
                end
                if (o_matched_input !== want.matched_input) begin
                    $error("matched_input: expected %0d, got %0d",
                           want.matched_input, o_matched_input);
                    err_count++;
                end
                if (o_iterations_used !== want.iterations_used) begin
                    $error("iterations_used: expected %0d, got %0d",
                           want.iterations_used, o_iterations_used);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    // Run the grant/accept passes for one request matrix and queue the results.
    task automatic predict_match(input logic [REQ_W-1:0] matrix);
        bit                 in_busy [NI];
        bit                 out_busy [NF];
        logic [INDEX_W-1:0] out_src [NF];
        bit                 grant_hit [NI][NF];
        int                 used;
        int                 conns;
        int                 c;
        int                 pos;
        t_match_result      r;
        used = 0;
        for (int i = 0; i < NI; i++) in_busy[i] = 1'b0;
        for (int f = 0; f < NF; f++) begin
            out_busy[f] = 1'b0;
            out_src[f] = '0;
        end
        for (int it = 0; it < int'(iter_limit); it++) begin
            conns = 0;
            for (int i = 0; i < NI; i++)
                for (int f = 0; f < NF; f++) grant_hit[i][f] = 1'b0;
            // Grant: each free output picks the next free requesting input.
            for (int f = 0; f < NF; f++) begin
                if (!out_busy[f]) begin
                    for (int k = 1; k <= NI; k++) begin
                        c = (int'(grant_ptr[f]) + k) % NI;
                        pos = c * NO + f / LPO;
                        if (pos < REQ_W && matrix[pos] && !in_busy[c]) begin
                            grant_ptr[f] = INDEX_W'(c);
                            grant_hit[c][f] = 1'b1;
                            break;
                        end
                    end
                end
            end
            // Accept: each free input takes the next granting output.
            for (int i = 0; i < NI; i++) begin
                if (!in_busy[i]) begin
                    for (int k = 1; k <= NF; k++) begin
                        c = (int'(accept_ptr[i]) + k) % NF;
                        if (grant_hit[i][c]) begin
                            accept_ptr[i] = INDEX_W'(c);
                            in_busy[i] = 1'b1;
                            out_busy[c] = 1'b1;
                            out_src[c] = INDEX_W'(i);
                            conns++;
                            break;
                        end
                    end
                end
            end
            if (conns == 0) break;
            used++;
        end
        if (used > 15) used = 15;
        for (int f = 0; f < NF; f++) begin
            r.fabric_output = INDEX_W'(f);
            r.matched = out_busy[f];
            r.matched_input = out_busy[f] ? out_src[f] : '0;
            r.iterations_used = ITER_W'(used);
            r.last = (f == NF - 1);
            expected_matches.push_back(r);
        end
    endtask

    // Offer one request matrix, with an occasional idle burst ahead of it.
    task automatic send_request(input logic [REQ_W-1:0] matrix);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_request_matrix <= matrix;
        forever begin
            @(posedge i_clk);
            if (o_req_ready) break;
        end
        predict_match(matrix);
    endtask

    // Stop offering requests and wait until every result has been taken.
    task automatic drain_matches();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Change the iteration limit while the block is idle.
    task automatic set_iterations(input logic [ITER_W-1:0] count);
        drain_matches();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= count;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        iter_limit = count;
    endtask

    // Random matrix whose density varies from sparse to nearly full.
    function automatic logic [REQ_W-1:0] random_matrix();
        logic [REQ_W-1:0] m;
        int               thresh;
        case ($urandom_range(0, 4))
            0: thresh = 1;
            1: thresh = 2;
            2: thresh = 4;
            3: thresh = 7;
            default: thresh = -1;
        endcase
        if (thresh < 0) begin
            m = {$urandom, $urandom};
        end else begin
            for (int b = 0; b < REQ_W; b++) m[b] = ($urandom_range(0, 7) < thresh);
        end
        return m;
    endfunction

    // Directed matrices under the reset limit of one pass.
    task automatic test_reset_limit();
        send_request('0);
        send_request('1);
        send_request(64'h0000_0000_0000_0001);
        send_request(64'h8000_0000_0000_0000);
        send_request(64'h8040_2010_0804_0201);
        send_request(64'h0101_0101_0101_0101);
        send_request(64'h0000_0000_FF00_0000);
        send_request('1);
    endtask

    // Zero passes, the widest count of fifteen and a limit of eight.
    task automatic test_iteration_extremes();
        set_iterations(4'd0);
        send_request('1);
        send_request(64'h0101_0101_0101_0101);
        set_iterations(4'd15);
        send_request('1);
        send_request(64'hAAAA_AAAA_AAAA_AAAA);
        send_request(64'h5555_5555_5555_5555);
        send_request(64'h0101_0101_0101_0101);
        set_iterations(4'd8);
        send_request('1);
        send_request(64'hFFFF_FFFF_0000_0000);
        send_request(64'h0000_0000_FFFF_FFFF);
        send_request(random_matrix());
    endtask

    // Random matrices over a range of iteration limits.
    task automatic test_random_limits();
        logic [ITER_W-1:0] limits [6];
        limits = '{4'd1, 4'd2, 4'd3, 4'd15, 4'd4, 4'd8};
        foreach (limits[n]) begin
            set_iterations(limits[n]);
            repeat (35) send_request(random_matrix());
        end
    endtask

    // The consumer holds off long enough that the block stops taking requests.
    task automatic test_output_backpressure();
        set_iterations(4'd8);
        res_hold_cycles = HOLD_CYCLES;
        repeat (10) send_request(random_matrix());
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate();
        set_iterations(4'($urandom_range(2, 6)));
        idle_on = 1'b0;
        repeat (40) send_request(random_matrix());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_req_valid = 1'b0;
        i_request_matrix = '0;
        i_res_ready = 1'b0;
        iter_limit = rrcm_pkg::ITER_RESET;
        for (int f = 0; f < NF; f++) grant_ptr[f] = '0;
        for (int i = 0; i < NI; i++) accept_ptr[i] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limit();
        test_iteration_extremes();
        test_random_limits();
        test_output_backpressure();
        test_full_rate();

        drain_matches();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/rrcm_pkg.sv
rtl/round_robin_crossbar_matcher_unit.sv
bench/tb.sv
